/* design/assert_macros.svh */
// Assertion macros shared by the scan code decoder RTL.
// Included by the files that check their own logic; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// Condition that must hold on the clock edge after reset was seen.
`define ASSERT_AFTER_RESET(label, clk, rst, cond) \
   label: assert property (@(posedge clk) (rst) |=> (cond)) \
      else $error("assertion failed: label");

`endif

/* design/scta_pkg.sv */
// Shared types, key codes and the key map for the scan code decoder.
// Used by scta_decode and scancode_to_ascii_decoder_unit; depends on nothing.
package scta_pkg;

   // Event codes carried on the result channel.
   typedef enum logic [2:0] {
      EV_CHAR    = 3'd0,
      EV_NEWLINE = 3'd1,
      EV_DELETE  = 3'd2,
      EV_SCROLL  = 3'd3,
      EV_SCREEN  = 3'd4,
      EV_CLEAR   = 3'd5
   } event_kind_type;

   // Set-1 make codes with special handling.
   localparam logic [7:0] KC_LSHIFT = 8'h2A;
   localparam logic [7:0] KC_RSHIFT = 8'h36;
   localparam logic [7:0] KC_LCTRL  = 8'h1D;
   localparam logic [7:0] KC_ENTER  = 8'h1C;
   localparam logic [7:0] KC_BSPACE = 8'h0E;
   localparam logic [7:0] KC_SPACE  = 8'h39;
   localparam logic [7:0] KC_CAPS   = 8'h3A;
   localparam logic [7:0] REL_BIT   = 8'h80;

   localparam logic [7:0] PRESS_LO   = 8'h01;
   localparam logic [7:0] PRESS_HI   = 8'h3A;
   localparam logic [7:0] RELEASE_LO = 8'h81;
   localparam logic [7:0] RELEASE_HI = 8'hBA;

   // Characters checked by the control shortcuts.
   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ONE   = 7'h31;
   localparam logic [6:0] CH_TWO   = 7'h32;
   localparam logic [6:0] CH_ELL   = 7'h6C;
   localparam logic [6:0] CH_LOW_A = 7'h61;
   localparam logic [6:0] CH_LOW_Z = 7'h7A;

   localparam logic [3:0] SCREEN_ONE = 4'd1;
   localparam logic [3:0] SCREEN_TWO = 4'd2;

   // Keyboard modifier state.
   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic ctrl_held;
   } flags_type;

   // One key map entry: unshifted and shifted characters, zero if unmapped.
   typedef struct packed {
      logic [6:0] plain;
      logic [6:0] shifted;
   } key_entry_type;

   // Decoder output for one scan code.
   typedef struct packed {
      logic           emit;
      event_kind_type kind;
      logic [6:0]     char_code;
      logic [3:0]     screen_index;
      flags_type      flags_next;
   } decode_result_type;

   // US layout key map indexed by the make code.
   function automatic key_entry_type key_map(input logic [5:0] index);
      key_entry_type entry;
      entry = '0;
      case (index)
         6'd2:  entry = '{7'h31, 7'h21};
         6'd3:  entry = '{7'h32, 7'h40};
         6'd4:  entry = '{7'h33, 7'h23};
         6'd5:  entry = '{7'h34, 7'h24};
         6'd6:  entry = '{7'h35, 7'h25};
         6'd7:  entry = '{7'h36, 7'h5E};
         6'd8:  entry = '{7'h37, 7'h26};
         6'd9:  entry = '{7'h38, 7'h2A};
         6'd10: entry = '{7'h39, 7'h28};
         6'd11: entry = '{7'h30, 7'h29};
         6'd12: entry = '{7'h2D, 7'h5F};
         6'd13: entry = '{7'h3D, 7'h2B};
         6'd16: entry = '{7'h71, 7'h51};
         6'd17: entry = '{7'h77, 7'h57};
         6'd18: entry = '{7'h65, 7'h45};
         6'd19: entry = '{7'h72, 7'h52};
         6'd20: entry = '{7'h74, 7'h54};
         6'd21: entry = '{7'h79, 7'h59};
         6'd22: entry = '{7'h75, 7'h55};
         6'd23: entry = '{7'h69, 7'h49};
         6'd24: entry = '{7'h6F, 7'h4F};
         6'd25: entry = '{7'h70, 7'h50};
         6'd26: entry = '{7'h5B, 7'h7B};
         6'd27: entry = '{7'h5D, 7'h7D};
         6'd30: entry = '{7'h61, 7'h41};
         6'd31: entry = '{7'h73, 7'h53};
         6'd32: entry = '{7'h64, 7'h44};
         6'd33: entry = '{7'h66, 7'h46};
         6'd34: entry = '{7'h67, 7'h47};
         6'd35: entry = '{7'h68, 7'h48};
         6'd36: entry = '{7'h6A, 7'h4A};
         6'd37: entry = '{7'h6B, 7'h4B};
         6'd38: entry = '{7'h6C, 7'h4C};
         6'd39: entry = '{7'h3B, 7'h3A};
         6'd40: entry = '{7'h27, 7'h22};
         6'd41: entry = '{7'h60, 7'h7E};
         6'd43: entry = '{7'h5C, 7'h7C};
         6'd44: entry = '{7'h7A, 7'h5A};
         6'd45: entry = '{7'h78, 7'h58};
         6'd46: entry = '{7'h63, 7'h43};
         6'd47: entry = '{7'h76, 7'h56};
         6'd48: entry = '{7'h62, 7'h42};
         6'd49: entry = '{7'h6E, 7'h4E};
         6'd50: entry = '{7'h6D, 7'h4D};
         6'd51: entry = '{7'h2C, 7'h3C};
         6'd52: entry = '{7'h2E, 7'h3E};
         6'd53: entry = '{7'h2F, 7'h3F};
         default: entry = '0;
      endcase
      return entry;
   endfunction

endpackage

/* design/scta_decode.sv */
// Combinational decode of one set-1 scan code against the modifier flags.
// Depends on scta_pkg for the key map, key codes and result types.
module scta_decode (
   input  logic [7:0]                  scan_code,
   input  scta_pkg::flags_type         flags,
   output scta_pkg::decode_result_type result
);

   logic                    is_press;
   logic                    is_release;
   scta_pkg::key_entry_type entry;
   logic                    alpha_key;
   logic                    use_shifted;

   // Key map lookup; the press range fits in the low six bits.
   assign entry       = scta_pkg::key_map(scan_code[5:0]);
   assign is_press    = scan_code inside {[scta_pkg::PRESS_LO:scta_pkg::PRESS_HI]};
   assign is_release  = scan_code inside {[scta_pkg::RELEASE_LO:scta_pkg::RELEASE_HI]};
   assign alpha_key   = entry.plain inside {[scta_pkg::CH_LOW_A:scta_pkg::CH_LOW_Z]};
   assign use_shifted = alpha_key ? (flags.caps_on ^ flags.shift_held) : flags.shift_held;

   // Event selection and flag update.
   always_comb begin
      result              = '0;
      result.kind         = scta_pkg::EV_CHAR;
      result.flags_next   = flags;
      if (is_press) begin
         case (scan_code)
            scta_pkg::KC_LSHIFT, scta_pkg::KC_RSHIFT: begin
               result.flags_next.shift_held = 1'b1;
            end
            scta_pkg::KC_LCTRL: begin
               result.flags_next.ctrl_held = 1'b1;
            end
            scta_pkg::KC_ENTER: begin
               result.emit = 1'b1;
               result.kind = scta_pkg::EV_NEWLINE;
            end
            scta_pkg::KC_BSPACE: begin
               result.emit = 1'b1;
               result.kind = scta_pkg::EV_DELETE;
            end
            scta_pkg::KC_SPACE: begin
               result.emit      = 1'b1;
               result.char_code = scta_pkg::CH_SPACE;
            end
            scta_pkg::KC_CAPS: begin
               result.emit                = 1'b1;
               result.kind                = scta_pkg::EV_SCROLL;
               result.flags_next.caps_on  = ~flags.caps_on;
            end
            default: begin
               if (entry.plain != 7'd0) begin
                  if (flags.ctrl_held) begin
                     // Control shortcuts consume the key and drop control.
                     result.flags_next.ctrl_held = 1'b0;
                     if (entry.plain == scta_pkg::CH_ONE) begin
                        result.emit         = 1'b1;
                        result.kind         = scta_pkg::EV_SCREEN;
                        result.screen_index = scta_pkg::SCREEN_ONE;
                     end else if (entry.plain == scta_pkg::CH_TWO) begin
                        result.emit         = 1'b1;
                        result.kind         = scta_pkg::EV_SCREEN;
                        result.screen_index = scta_pkg::SCREEN_TWO;
                     end else if (entry.plain == scta_pkg::CH_ELL) begin
                        result.emit = 1'b1;
                        result.kind = scta_pkg::EV_CLEAR;
                     end
                  end else begin
                     result.emit      = 1'b1;
                     result.char_code = use_shifted ? entry.shifted : entry.plain;
                  end
               end
            end
         endcase
      end else if (is_release) begin
         // Only modifier releases matter.
         if (scan_code == (scta_pkg::KC_LSHIFT | scta_pkg::REL_BIT) ||
             scan_code == (scta_pkg::KC_RSHIFT | scta_pkg::REL_BIT)) begin
            result.flags_next.shift_held = 1'b0;
         end else if (scan_code == (scta_pkg::KC_LCTRL | scta_pkg::REL_BIT)) begin
            result.flags_next.ctrl_held = 1'b0;
         end
      end
   end

endmodule

/* design/scancode_to_ascii_decoder_unit.sv */
// Top level of the set-1 scan code to ASCII event decoder.
// Depends on scta_pkg, scta_decode and assert_macros.svh.
//
// Usage:
//   Input channel req_: one raw scan code byte per beat on req_scan_code.
//   Result channel rsp_: one event per beat (kind, character, screen index).
//   A beat moves at a clock edge where valid is high and stall is low.
//   Each code is decoded against the shift, caps lock and control flags;
//   releases, shift and control presses, unmapped keys and codes outside the press and
//   release ranges update flags only and produce no result beat.
//   A code passes through the input register and then the result register before its result appears on rsp_.
//   Throughput: one code per cycle while req_stall is low; the input register
//   and the result register form a two-stage pipeline, so req_stall rises only
//   when both are full and rsp_stall is high.
//   While the receiver stalls, the result register holds its beat and the
//   input register holds the next code; flags change only when a code leaves
//   the input register.
//   Reset clears all flags and empties both registers.
`include "assert_macros.svh"

module scancode_to_ascii_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_scan_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_kind,
   output logic [6:0] rsp_char_code,
   output logic [3:0] rsp_screen_index
);

   logic                        stage_valid_ff, stage_valid_in;
   logic [7:0]                  stage_code_ff;
   logic                        out_valid_ff, out_valid_in;
   scta_pkg::event_kind_type    out_kind_ff;
   logic [6:0]                  out_char_ff;
   logic [3:0]                  out_screen_ff;
   scta_pkg::flags_type         flags_ff, flags_in;
   scta_pkg::decode_result_type decoded;
   logic                        advance;
   logic                        fire;
   logic                        take_in;

   // Pipeline control.
   assign advance        = ~out_valid_ff | ~rsp_stall;
   assign fire           = stage_valid_ff & advance;
   assign req_stall      = stage_valid_ff & ~advance;
   assign take_in        = req_valid & ~req_stall;
   assign stage_valid_in = req_stall ? stage_valid_ff : req_valid;
   assign out_valid_in   = advance ? (fire & decoded.emit) : out_valid_ff;
   assign flags_in       = fire ? decoded.flags_next : flags_ff;

   // Decode of the registered code.
   scta_decode u_decode (
      .scan_code (stage_code_ff),
      .flags     (flags_ff),
      .result    (decoded)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         flags_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         flags_ff       <= flags_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_in) begin
         stage_code_ff <= req_scan_code;
      end
      if (fire && decoded.emit) begin
         out_kind_ff   <= decoded.kind;
         out_char_ff   <= decoded.char_code;
         out_screen_ff <= decoded.screen_index;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_char_code    = out_char_ff;
   assign rsp_screen_index = out_screen_ff;

   // Checks on the pipeline and the result encoding.
   `ASSERT_AFTER_RESET(a_empty_after_reset, clock, reset, !rsp_valid && !req_stall)
   `ASSERT_ALWAYS(a_stall_needs_full, clock, reset,
                  req_stall |-> (stage_valid_ff && out_valid_ff))
   `ASSERT_ALWAYS(a_char_only_for_char, clock, reset,
                  (rsp_valid && rsp_event_kind != scta_pkg::EV_CHAR) |-> rsp_char_code == 7'd0)
   `ASSERT_ALWAYS(a_screen_only_for_screen, clock, reset,
                  (rsp_valid && rsp_event_kind != scta_pkg::EV_SCREEN) |->
                  rsp_screen_index == 4'd0)

endmodule

/* dv/testbench.sv */
// Self-checking testbench for scancode_to_ascii_decoder_unit.
// Drives set-1 scan codes, predicts key events in a scoreboard class and compares them.
// Depends on scta_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module testbench;
   import scta_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_CODES = 1325;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_OFF_LEN = 150;

   // One predicted key event, as it appears on the result channel.
   typedef struct {
      event_kind_type kind;
      logic [6:0]     char_code;
      logic [3:0]     screen_index;
   } key_event_type;

   // Tracks the modifier flags and the queue of key events still owed by the block.
   class key_event_tracker;
      // Characters by make code; a blank marks a key with no character.
      string plain_keys   = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./     ";
      string shifted_keys = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?     ";
      bit shift_held;
      bit caps_on;
      bit ctrl_held;
      key_event_type pending_events[$];
      int mismatches;

      function void queue_event(event_kind_type kind, logic [6:0] ch, logic [3:0] scr);
         key_event_type ev;
         ev.kind = kind;
         ev.char_code = ch;
         ev.screen_index = scr;
         pending_events.push_back(ev);
      endfunction

      // Update the flags for one accepted scan code and queue the event it causes.
      function void note_scan_code(logic [7:0] code);
         byte base;
         bit  use_shifted;
         if (code >= PRESS_LO && code <= PRESS_HI) begin
            case (code)
               KC_LSHIFT, KC_RSHIFT: shift_held = 1'b1;
               KC_LCTRL:  ctrl_held = 1'b1;
               KC_ENTER:  queue_event(EV_NEWLINE, '0, '0);
               KC_BSPACE: queue_event(EV_DELETE, '0, '0);
               KC_SPACE:  queue_event(EV_CHAR, CH_SPACE, '0);
               KC_CAPS: begin
                  caps_on = !caps_on;
                  queue_event(EV_SCROLL, '0, '0);
               end
               default: begin
                  base = plain_keys[code];
                  if (base == " ") return;
                  // Control turns a mapped key into a shortcut, or into nothing.
                  if (ctrl_held) begin
                     ctrl_held = 1'b0;
                     if (base == CH_ONE) queue_event(EV_SCREEN, '0, SCREEN_ONE);
                     else if (base == CH_TWO) queue_event(EV_SCREEN, '0, SCREEN_TWO);
                     else if (base == CH_ELL) queue_event(EV_CLEAR, '0, '0);
                     return;
                  end
                  // Caps lock only affects letters.
                  if (base >= CH_LOW_A && base <= CH_LOW_Z) use_shifted = caps_on ^ shift_held;
                  else use_shifted = shift_held;
                  queue_event(EV_CHAR, 7'(use_shifted ? shifted_keys[code] : base), '0);
               end
            endcase
         end else if (code >= RELEASE_LO && code <= RELEASE_HI) begin
            if (code == (KC_LSHIFT | REL_BIT) || code == (KC_RSHIFT | REL_BIT))
               shift_held = 1'b0;
            else if (code == (KC_LCTRL | REL_BIT))
               ctrl_held = 1'b0;
         end
      endfunction

      function void report_mismatch(string what, key_event_type want, logic [2:0] kind,
                                    logic [6:0] ch, logic [3:0] scr);
         mismatches++;
         if (mismatches <= 10)
            $display({"MISMATCH %s: expected kind %0d char %h screen %0d, ",
                      "got kind %0d char %h screen %0d"},
                     what, want.kind, want.char_code, want.screen_index, kind, ch, scr);
      endfunction

      // Compare one result beat against the oldest predicted event.
      function void check_event(logic [2:0] kind, logic [6:0] ch, logic [3:0] scr);
         key_event_type want;
         if (pending_events.size() == 0) begin
            want.kind = EV_CHAR;
            want.char_code = '0;
            want.screen_index = '0;
            report_mismatch("unexpected beat", want, kind, ch, scr);
            return;
         end
         want = pending_events.pop_front();
         if (want.kind !== kind || want.char_code !== ch || want.screen_index !== scr)
            report_mismatch("field", want, kind, ch, scr);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_scan_code;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_event_kind;
   logic [6:0] rsp_char_code;
   logic [3:0] rsp_screen_index;

   key_event_tracker tracker = new();
   int send_idle_pct = 24;
   int rsp_idle_pct  = 24;
   int hold_off_cycles = 0;

   scancode_to_ascii_decoder_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_code    (req_scan_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_char_code    (rsp_char_code),
      .rsp_screen_index (rsp_screen_index)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_scan_code = '0;
      rsp_stall = 1'b0;
   end

   always #5 clock = ~clock;

   // Offer one scan code at the falling edge and wait for the beat to be taken.
   task automatic send_code(input logic [7:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_scan_code <= code;
      do @(posedge clock); while (req_stall);
      tracker.note_scan_code(code);
      @(negedge clock);
   endtask

   // Mostly key sequences a typist would produce, with some noise.
   function automatic logic [7:0] random_scan_code();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return 8'($urandom_range(2, 53));
      if (pick < 55) return $urandom_range(1) ? KC_LSHIFT : KC_RSHIFT;
      if (pick < 63) return $urandom_range(1) ? (KC_LSHIFT | REL_BIT) : (KC_RSHIFT | REL_BIT);
      if (pick < 70) return KC_LCTRL;
      if (pick < 74) return KC_LCTRL | REL_BIT;
      if (pick < 80) begin
         case ($urandom_range(2))
            0: return 8'h02;
            1: return 8'h03;
            default: return 8'h26;
         endcase
      end
      if (pick < 83) return KC_CAPS;
      if (pick < 88) begin
         case ($urandom_range(2))
            0: return KC_ENTER;
            1: return KC_BSPACE;
            default: return KC_SPACE;
         endcase
      end
      if (pick < 94) return 8'($urandom_range(RELEASE_LO, RELEASE_HI));
      return 8'($urandom_range(255));
   endfunction

   // Receiver: random stalls, plus one long hold-off when requested.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Check every result beat at the rising edge where it moves.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_event(rsp_event_kind, rsp_char_code, rsp_screen_index);
   end

   // Watchdog on the total run length.
   initial begin
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("scancode_to_ascii_decoder_unit test failed");
      $finish;
   end

   // Main sequence: reset, directed codes, random codes, drain.
   initial begin
      logic [7:0] directed_codes[$];
      directed_codes = '{8'h00, 8'hFF, 8'h80, 8'h3B, 8'hBB, 8'h02, 8'h1E, 8'h1C, 8'h0E,
                         8'h39, 8'h3A, 8'h1E, 8'h2A, 8'h1E, 8'h02, 8'hB6, 8'h1D, 8'h1C,
                         8'h02, 8'h1D, 8'h03, 8'h1D, 8'h26, 8'h1D, 8'h10, 8'h9D, 8'h3A};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_codes[i])
         send_code(directed_codes[i]);

      for (int i = 0; i < RANDOM_CODES; i++) begin
         // Long receiver hold-off early on, then a stretch with no idling at all.
         if (i == 100) hold_off_cycles = HOLD_OFF_LEN;
         if (i == 400) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (i == 700) begin
            send_idle_pct = 24;
            rsp_idle_pct = 24;
         end
         send_code(random_scan_code());
      end
      req_valid <= 1'b0;

      // Wait for every predicted event, then give the pipeline time to settle.
      while (tracker.pending_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("scancode_to_ascii_decoder_unit test passed");
      else
         $display("scancode_to_ascii_decoder_unit test failed");
      $finish;
   end
endmodule

/* scancode_to_ascii_decoder_unit.f */
+incdir+design
design/scta_pkg.sv
design/scta_decode.sv
design/scancode_to_ascii_decoder_unit.sv
dv/testbench.sv
